### rtl/fir29_pkg.sv
// Shared constants, codes and types for the 29-tap FIR filter.
`timescale 1ns / 1ps

package fir29_pkg;

   // Default sizes of the filter.
   localparam int TAPS_DEF        = 29;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF   = 18;

   // Fixed field widths of the channels.
   localparam int OUT_BITS       = 38;
   localparam int TAP_INDEX_BITS = 5;

   // Function codes of a request word.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   // Partial sum handed from one cell to the next.
   typedef struct packed {
      logic                valid;
      logic [OUT_BITS-1:0] sum;
   } link_type;

endpackage

### rtl/fir29_channels.sv
// Valid/ready channel interfaces for the request and response sides of the FIR filter.
`timescale 1ns / 1ps

interface fir29_req_if #(
   parameter int SAMPLE_BITS = fir29_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fir29_pkg::COEF_BITS_DEF
);
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic [fir29_pkg::TAP_INDEX_BITS-1:0] tap_index;
   logic signed [SAMPLE_BITS-1:0]       sample;
   logic signed [COEF_BITS-1:0]         coefficient;

   modport source (output valid, output func, output tap_index, output sample,
                   output coefficient, input ready);
   modport sink   (input valid, input func, input tap_index, input sample,
                   input coefficient, output ready);
endinterface

interface fir29_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fir29_pkg::OUT_BITS-1:0] filtered;

   modport source (output valid, output filtered, input ready);
   modport sink   (input valid, input filtered, output ready);
endinterface

### rtl/fir29_cell.sv
// One tap cell of the FIR chain: delay stage, coefficient, product and partial-sum stage.
`timescale 1ns / 1ps

module fir29_cell #(
   parameter int SAMPLE_BITS = fir29_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fir29_pkg::COEF_BITS_DEF,
   parameter int CELL_INDEX  = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 shift_en,
   input  logic signed [SAMPLE_BITS-1:0]        sample_in,
   output logic signed [SAMPLE_BITS-1:0]        sample_out,
   input  logic                                 load_en,
   input  logic [fir29_pkg::TAP_INDEX_BITS-1:0] load_index,
   input  logic signed [COEF_BITS-1:0]          load_coef,
   input  fir29_pkg::link_type                  link_in,
   output fir29_pkg::link_type                  link_out
);

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam int EXT_W  = (PROD_W > fir29_pkg::OUT_BITS) ? PROD_W : fir29_pkg::OUT_BITS;
   localparam bit IN_RANGE = CELL_INDEX < (1 << fir29_pkg::TAP_INDEX_BITS);
   localparam logic [fir29_pkg::TAP_INDEX_BITS-1:0] MY_INDEX =
      fir29_pkg::TAP_INDEX_BITS'(CELL_INDEX);

   logic signed [SAMPLE_BITS-1:0]     tap_ff, tap_in;
   logic signed [COEF_BITS-1:0]       coef_ff, coef_in;
   logic [fir29_pkg::OUT_BITS-1:0]    prod_ff, prod_in;
   fir29_pkg::link_type               link_ff, link_in_next;
   logic signed [PROD_W-1:0]          product;
   logic signed [EXT_W-1:0]           product_ext;
   logic                              hit;

   assign hit         = load_en && IN_RANGE && (load_index == MY_INDEX);
   assign tap_in      = shift_en ? sample_in : tap_ff;
   assign coef_in     = hit ? load_coef : coef_ff;
   assign product     = tap_ff * coef_ff;
   assign product_ext = EXT_W'(product);
   // Products wrap to the output width, as the final sum does.
   assign prod_in     = product_ext[fir29_pkg::OUT_BITS-1:0];

   always_comb begin
      link_in_next.valid = link_in.valid;
      link_in_next.sum   = link_in.sum + prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff  <= '0;
         coef_ff <= '0;
         prod_ff <= '0;
         link_ff <= '0;
      end else begin
         tap_ff  <= tap_in;
         coef_ff <= coef_in;
         prod_ff <= prod_in;
         link_ff <= link_in_next;
      end
   end

   assign sample_out = tap_ff;
   assign link_out   = link_ff;

endmodule

### rtl/fir_filter_29_tap.sv
// Top level of the 29-tap direct-form FIR filter built as a chain of tap cells.
//
//   Channel   Direction  Fields                                   Accepted when
//   req       in         func, tap_index, sample, coefficient     req.valid && req.ready
//   rsp       out        filtered                                 rsp.valid && rsp.ready
//
// A coefficient-load word writes the addressed cell; an index at or beyond TAPS is
// dropped. A sample word shifts the delay line in every cell at once, then a
// partial sum walks the cell chain one cell per cycle. After a sample, req.ready
// stays low while the sample moves through start_ff, go_ff and the cell chain and
// until its sum has left the holding register, so no new word is taken before. The
// finished sum sits in a holding register and then in the output register, so a
// new word is taken while a result waits on rsp; only a sum that finds the output
// register still full keeps req.ready low longer.
// Reset (synchronous) clears the delay line, the coefficients and all valid flags.
`timescale 1ns / 1ps

module fir_filter_29_tap #(
   parameter int TAPS        = fir29_pkg::TAPS_DEF,
   parameter int SAMPLE_BITS = fir29_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fir29_pkg::COEF_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   fir29_req_if.sink   req,
   fir29_rsp_if.source rsp
);

   // Delay-line taps and partial-sum links between neighboring cells.
   logic signed [SAMPLE_BITS-1:0] taps [TAPS+1];
   fir29_pkg::link_type           links [TAPS+1];
   logic [TAPS-1:0]               chain_valid;

   logic accept;
   logic sample_take;
   logic load_take;
   logic busy;

   // Sequencing: start_ff marks the shift, go_ff the cycle after it, when every
   // cell's product register already holds the new product.
   logic                           start_ff, start_in;
   logic                           go_ff, go_in;
   logic                           pending_valid_ff, pending_valid_in;
   logic [fir29_pkg::OUT_BITS-1:0] pending_ff, pending_in;
   logic                           out_valid_ff, out_valid_in;
   logic [fir29_pkg::OUT_BITS-1:0] out_data_ff, out_data_in;
   logic                           out_free;

   // The block is busy from a sample's acceptance until its sum has left the
   // holding register for the output register.
   assign busy        = start_ff || go_ff || (|chain_valid) || pending_valid_ff;
   assign req.ready   = !busy;
   assign accept      = req.valid && !busy;
   assign sample_take = accept && (req.func == fir29_pkg::FUNC_SAMPLE);
   assign load_take   = accept && (req.func == fir29_pkg::FUNC_LOAD);

   assign taps[0]        = req.sample;
   assign links[0].valid = go_ff;
   assign links[0].sum   = '0;

   genvar k;
   generate
      for (k = 0; k < TAPS; k++) begin : g_cell
         fir29_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS),
            .CELL_INDEX  (k)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (sample_take),
            .sample_in  (taps[k]),
            .sample_out (taps[k+1]),
            .load_en    (load_take),
            .load_index (req.tap_index),
            .load_coef  (req.coefficient),
            .link_in    (links[k]),
            .link_out   (links[k+1])
         );
         assign chain_valid[k] = links[k+1].valid;
      end
   endgenerate

   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      start_in         = sample_take;
      go_in            = start_ff;
      pending_valid_in = pending_valid_ff;
      pending_in       = pending_ff;
      out_valid_in     = out_valid_ff;
      out_data_in      = out_data_ff;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      // The holding register moves on as soon as the output register is free.
      if (pending_valid_ff && out_free) begin
         out_valid_in     = 1'b1;
         out_data_in      = pending_ff;
         pending_valid_in = 1'b0;
      end
      // The last cell's sum lands in the holding register, which is empty then.
      if (links[TAPS].valid) begin
         pending_valid_in = 1'b1;
         pending_in       = links[TAPS].sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff         <= 1'b0;
         go_ff            <= 1'b0;
         pending_valid_ff <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         start_ff         <= start_in;
         go_ff            <= go_in;
         pending_valid_ff <= pending_valid_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff  <= pending_in;
      out_data_ff <= out_data_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.filtered = out_data_ff;

endmodule

### tb/sv/fir_filter_29_tap_tb.sv
// Self-checking testbench for the 29-tap FIR filter: directed table, then biased random words.
`timescale 1ns / 1ps

module fir_filter_29_tap_tb;

   localparam int TAPS      = fir29_pkg::TAPS_DEF;
   localparam int SAMP_W    = fir29_pkg::SAMPLE_BITS_DEF;
   localparam int COEF_W    = fir29_pkg::COEF_BITS_DEF;
   localparam int IDX_W     = fir29_pkg::TAP_INDEX_BITS;
   localparam int OUT_W     = fir29_pkg::OUT_BITS;
   localparam int CHAIN_LAT = TAPS + 3;

   // Most negative and most positive values of the two input formats.
   localparam logic signed [SAMP_W-1:0] SAMPLE_MIN = {1'b1, {(SAMP_W-1){1'b0}}};
   localparam logic signed [SAMP_W-1:0] SAMPLE_MAX = {1'b0, {(SAMP_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic signed [COEF_W-1:0] COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};

   // One row of the directed table. When has_want is set, the row carries the
   // filter output worked out by hand and that value is what the result must match.
   typedef struct {
      logic                     func;
      logic [IDX_W-1:0]         tap_index;
      logic signed [SAMP_W-1:0] sample;
      logic signed [COEF_W-1:0] coefficient;
      bit                       has_want;
      logic signed [OUT_W-1:0]  want;
   } directed_row_type;

   logic clock;
   logic reset;

   fir29_req_if req_ch ();
   fir29_rsp_if rsp_ch ();

   fir_filter_29_tap i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Our own copy of the filter state: the newest sample sits at position 0.
   logic signed [SAMP_W-1:0] delay_taps [TAPS];
   logic signed [COEF_W-1:0] coef_taps  [TAPS];
   logic signed [OUT_W-1:0]  pending_filtered [$];

   int mismatch_count  = 0;
   int words_counted   = 0;
   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   bit hold_off_req    = 1'b0;

   directed_row_type directed_rows [17];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The run is cut off well beyond the slowest legal run, even with every stall stacked up.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic void report_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endfunction

   // Applies one accepted word to the state copy. A load writes the addressed
   // coefficient (indexes past the last tap are dropped) and yields nothing. A
   // sample shifts the delay line and yields the full sum of products; with the
   // default widths the sum always fits in the 38-bit output.
   task automatic filter_word(input logic func, input logic [IDX_W-1:0] tap_index,
                              input logic signed [SAMP_W-1:0] sample,
                              input logic signed [COEF_W-1:0] coefficient,
                              output bit produced, output logic signed [OUT_W-1:0] sum);
      longint acc;
      acc      = 0;
      produced = 1'b0;
      sum      = '0;
      if (func == fir29_pkg::FUNC_LOAD) begin
         if (tap_index < TAPS) coef_taps[tap_index] = coefficient;
      end else begin
         for (int k = TAPS - 1; k > 0; k--) delay_taps[k] = delay_taps[k-1];
         delay_taps[0] = sample;
         for (int k = 0; k < TAPS; k++) acc += longint'(delay_taps[k]) * longint'(coef_taps[k]);
         sum      = acc[OUT_W-1:0];
         produced = 1'b1;
      end
   endtask

   // Offers one word, with random idle cycles first, and waits for the handshake.
   // On acceptance the word goes through the state copy; the expected result is
   // the hand-worked value where the caller gives one, else the computed sum.
   task automatic send_word(input logic func, input logic [IDX_W-1:0] tap_index,
                            input logic signed [SAMP_W-1:0] sample,
                            input logic signed [COEF_W-1:0] coefficient,
                            input bit has_want, input logic signed [OUT_W-1:0] want);
      bit                      produced;
      logic signed [OUT_W-1:0] sum;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= func;
      req_ch.tap_index   <= tap_index;
      req_ch.sample      <= sample;
      req_ch.coefficient <= coefficient;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      filter_word(func, tap_index, sample, coefficient, produced, sum);
      if (produced) pending_filtered.push_back(has_want ? want : sum);
      // Loads that land past the last tap change nothing, so they are not counted.
      if (func == fir29_pkg::FUNC_SAMPLE || tap_index < TAPS) words_counted++;
   endtask

   // Sample and coefficient pickers lean toward the extremes of each format.
   function automatic logic signed [SAMP_W-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         2:       return '0;
         default: return SAMP_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [COEF_W-1:0] pick_coefficient();
      case ($urandom_range(7))
         0:       return COEF_MIN;
         1:       return COEF_MAX;
         2:       return '0;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   task automatic load_all_taps(input bit uniform, input logic signed [COEF_W-1:0] value);
      for (int k = 0; k < TAPS; k++)
         send_word(fir29_pkg::FUNC_LOAD, IDX_W'(k), SAMP_W'($urandom),
                   uniform ? value : pick_coefficient(), 1'b0, '0);
   endtask

   task automatic sample_run(input int count, input bit uniform,
                             input logic signed [SAMP_W-1:0] value);
      for (int n = 0; n < count; n++)
         send_word(fir29_pkg::FUNC_SAMPLE, IDX_W'($urandom), uniform ? value : pick_sample(),
                   COEF_W'($urandom), 1'b0, '0);
   endtask

   // Random traffic: mostly runs of samples over a freshly loaded coefficient
   // set, mixed with lone loads, some of them to indexes past the last tap.
   task automatic random_traffic(input int count);
      int               goal;
      logic [IDX_W-1:0] idx;
      goal = words_counted + count;
      while (words_counted < goal) begin
         case ($urandom_range(9))
            0: begin
               if ($urandom_range(3) == 0)
                  load_all_taps(1'b1, $urandom_range(1) ? COEF_MIN : COEF_MAX);
               else load_all_taps(1'b0, '0);
            end
            1, 2: begin
               idx = IDX_W'(($urandom_range(7) == 0) ? $urandom_range(TAPS, 31)
                                                     : $urandom_range(TAPS - 1));
               send_word(fir29_pkg::FUNC_LOAD, idx, SAMP_W'($urandom), pick_coefficient(),
                         1'b0, '0);
            end
            default: begin
               if ($urandom_range(5) == 0)
                  sample_run($urandom_range(1, 20), 1'b1,
                             $urandom_range(1) ? SAMPLE_MIN : SAMPLE_MAX);
               else
                  sample_run($urandom_range(1, 20), 1'b0, '0);
            end
         endcase
      end
   endtask

   // Response side: random stalls, plus one long hold-off on request so the
   // filter's holding stages fill up and it has to stall its input.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (int n = 0; n < 300; n++) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Every accepted result is matched against the oldest outstanding expectation.
   always @(posedge clock) begin
      logic signed [OUT_W-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_filtered.size() == 0) begin
            report_failure($sformatf("unexpected result: filtered=%0d", rsp_ch.filtered));
         end else begin
            want = pending_filtered.pop_front();
            if (rsp_ch.filtered !== want)
               report_failure($sformatf("filtered mismatch: expected %0d, got %0d",
                                        want, rsp_ch.filtered));
         end
      end
   end

   initial begin
      int guard;

      // Directed words. With all coefficients cleared, the first samples must
      // give zero. A lone coefficient at tap 0 then gives exactly that
      // coefficient times the newest sample, including the corner where both
      // operands are at their most negative. Loads at indexes 29 and 31 must
      // be dropped, and the sample after them still sees only tap 0 and an
      // empty tap 28 (too few samples have gone in to reach it).
      directed_rows = '{
         '{fir29_pkg::FUNC_SAMPLE, 5'd0,  SAMPLE_MAX, '0,          1'b1, '0},
         '{fir29_pkg::FUNC_SAMPLE, 5'd0,  SAMPLE_MIN, '0,          1'b1, '0},
         '{fir29_pkg::FUNC_LOAD,   5'd0,  '0,         COEF_MIN,    1'b0, '0},
         '{fir29_pkg::FUNC_SAMPLE, 5'd0,  SAMPLE_MIN, '0,          1'b1, 38'sd4294967296},
         '{fir29_pkg::FUNC_SAMPLE, 5'd0,  SAMPLE_MAX, '0,          1'b1, -38'sd4294836224},
         '{fir29_pkg::FUNC_LOAD,   5'd28, '0,         COEF_MAX,    1'b0, '0},
         '{fir29_pkg::FUNC_LOAD,   5'd29, '0,         18'sd77,     1'b0, '0},
         '{fir29_pkg::FUNC_LOAD,   5'd31, '0,         -18'sd1,     1'b0, '0},
         '{fir29_pkg::FUNC_SAMPLE, 5'd0,  '0,         '0,          1'b1, '0},
         '{fir29_pkg::FUNC_LOAD,   5'd14, '0,         -18'sd1,     1'b0, '0},
         '{fir29_pkg::FUNC_LOAD,   5'd21, '0,         18'sh15555,  1'b0, '0},
         '{fir29_pkg::FUNC_LOAD,   5'd10, '0,         18'sh2AAAA,  1'b0, '0},
         '{fir29_pkg::FUNC_SAMPLE, 5'd0,  16'sh5555,  '0,          1'b0, '0},
         '{fir29_pkg::FUNC_SAMPLE, 5'd31, 16'shAAAA,  18'sh3FFFF,  1'b0, '0},
         '{fir29_pkg::FUNC_LOAD,   5'd0,  16'shFFFF,  '0,          1'b0, '0},
         '{fir29_pkg::FUNC_SAMPLE, 5'd0,  16'sd1,     '0,          1'b0, '0},
         '{fir29_pkg::FUNC_SAMPLE, 5'd0,  -16'sd1,    '0,          1'b0, '0}
      };

      for (int k = 0; k < TAPS; k++) begin
         delay_taps[k] = '0;
         coef_taps[k]  = '0;
      end

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= fir29_pkg::FUNC_SAMPLE;
      req_ch.tap_index   <= '0;
      req_ch.sample      <= '0;
      req_ch.coefficient <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First phase: the sender idles now and then, the receiver often.
      send_idle_pct = 24;
      recv_idle_pct = 52;
      foreach (directed_rows[i])
         send_word(directed_rows[i].func, directed_rows[i].tap_index, directed_rows[i].sample,
                   directed_rows[i].coefficient, directed_rows[i].has_want,
                   directed_rows[i].want);
      random_traffic(130);

      // Second phase: the idling is swapped between the two sides.
      send_idle_pct = 52;
      recv_idle_pct = 24;
      random_traffic(130);

      // Third phase: no idling. It opens with the long receiver hold-off while
      // words keep coming, then drives the sum to its largest magnitudes: every
      // tap at the most negative coefficient against a full line of the most
      // negative sample, then the same line against the most positive coefficient.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_req  = 1'b1;
      load_all_taps(1'b1, COEF_MIN);
      sample_run(TAPS, 1'b1, SAMPLE_MIN);
      load_all_taps(1'b1, COEF_MAX);
      sample_run(TAPS, 1'b1, SAMPLE_MIN);
      random_traffic(30);

      // The last word was taken at this edge, so it must not be offered again.
      req_ch.valid <= 1'b0;

      // Drain, then give the chain time to show any stray result.
      guard = 0;
      while (pending_filtered.size() != 0 && guard < 20 * CHAIN_LAT) begin
         @(posedge clock);
         guard++;
      end
      repeat (2 * CHAIN_LAT) @(posedge clock);
      while (pending_filtered.size() != 0)
         report_failure($sformatf("missing result: expected filtered=%0d",
                                  pending_filtered.pop_front()));

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
